>>> rtl/cxr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cxr_pkg
// Shared constants and elaboration-time functions for the xy-to-sRGB core:
// matrix coefficients and the inverse-gamma code thresholds.
// ----------------------------------------------------------------------------
package cxr_pkg;

    localparam int DEF_GAMMA_TABLE_BITS = 12;
    localparam int DEF_COEF_FRAC_BITS   = 16;
    localparam int NCH                  = 3;
    localparam int THR_W                = 16;
    localparam int NCODE                = 256;

    // xyz to linear srgb, units of 1e-7, rows r, g, b
    localparam int MAT_E7 [9] = '{
        32404542, -15371385, -4985314,
        -9692660,  18760108,   415560,
          556434,  -2040259, 10572252
    };

    typedef logic [NCODE-1:0][THR_W-1:0] t_thr_tab;

    // round to nearest, halves away from zero
    function automatic longint coef_q(input int idx, input int cf);
        longint m;
        longint mag;
        longint q;
        m   = longint'(MAT_E7[idx]);
        mag = (m < 0) ? -m : m;
        q   = ((mag << cf) + 64'sd5000000) / 64'sd10000000;
        return (m < 0) ? -q : q;
    endfunction

    function automatic longint unsigned pow5_q30(input longint unsigned r);
        longint unsigned r2;
        longint unsigned r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // linear level where the encoded value crosses (k-0.5)/255, q30
    function automatic longint unsigned lin_threshold(input int k);
        longint unsigned w;
        longint unsigned w2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 30;
        if (k <= 10) begin
            return ((longint'(2 * k - 1) * 100) << 30) / 64'd658920;
        end
        w  = (longint'(400 * k + 5410) << 30) / 64'd107610;
        w2 = (w * w) >> 30;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow5_q30(mid) <= w2) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (w2 * lo) >> 30;
    endfunction

    // table index at which each output code starts, entry 0 unused
    function automatic t_thr_tab build_thr(input int gbits);
        t_thr_tab        tab;
        longint unsigned n1;
        longint unsigned t;
        tab = '0;
        n1  = (64'd1 << gbits) - 1;
        for (int k = 1; k < NCODE; k++) begin
            t      = (lin_threshold(k) * n1 + (64'd1 << 30) - 1) >> 30;
            tab[k] = t[THR_W-1:0];
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cie_xy_to_rgb_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cie_xy_to_rgb_core
// CIE 1931 xy chromaticity plus brightness level to 8-bit gamma-encoded sRGB.
// ----------------------------------------------------------------------------
// Fully pipelined: busy stays low and a command is taken on every cycle that
// start is high. Each command gives one result, shown with o_done for one
// cycle. The pipeline runs through the restoring divider, one quotient bit
// per stage, and the eight-stage binary search over the output code
// thresholds. The receiver cannot stall; results come out in command order.
module cie_xy_to_rgb_core
    import cxr_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = DEF_GAMMA_TABLE_BITS,
    parameter int COEF_FRAC_BITS   = DEF_COEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_chroma_x,
    input  wire logic [15:0] i_chroma_y,
    input  wire logic [7:0]  i_level,
    output logic             o_done,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    localparam int G    = GAMMA_TABLE_BITS;
    localparam int CF   = COEF_FRAC_BITS;
    localparam int CW   = CF + 3;
    localparam int PW   = CF + 21;
    localparam int NW   = CF + 23;
    localparam int PPW  = NW + 7;
    localparam int DW   = CF + 24;
    localparam int AW   = DW + G;
    localparam int NSRC = 8;
    localparam int LAT  = G + 14;

    localparam logic [G-1:0] N1 = {G{1'b1}};
    localparam t_thr_tab THR = build_thr(G);

    localparam logic signed [CW-1:0] COEF [9] = '{
        CW'(coef_q(0, CF)), CW'(coef_q(1, CF)), CW'(coef_q(2, CF)),
        CW'(coef_q(3, CF)), CW'(coef_q(4, CF)), CW'(coef_q(5, CF)),
        CW'(coef_q(6, CF)), CW'(coef_q(7, CF)), CW'(coef_q(8, CF))
    };

    logic [LAT-1:0] r_vld;

    // stage 1: inputs
    logic        [15:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic        [7:0]  r_lvl1;
    logic        [15:0] n_y;

    // stage 2: constant products
    logic signed [PW-1:0] r_px [NCH];
    logic signed [PW-1:0] r_py [NCH];
    logic signed [PW-1:0] r_pz [NCH];
    logic        [15:0]   r_y2;
    logic        [7:0]    r_lvl2;

    // stage 3: numerator, denominator
    logic signed [NW-1:0] r_num [NCH];
    logic        [DW-1:0] r_den3;
    logic        [7:0]    r_lvl3;

    // stage 4: scaled numerator
    logic [PPW-1:0] r_p [NCH];
    logic [NCH-1:0] r_zero4;
    logic [DW-1:0]  r_den4;

    // divider, index 0 is the setup stage
    logic [DW-1:0]  r_rem  [G+1][NCH];
    logic [G-1:0]   r_lo   [G+1][NCH];
    logic [G-1:0]   r_q    [G+1][NCH];
    logic [NCH-1:0] r_sat  [G+1];
    logic [NCH-1:0] r_zero [G+1];
    logic [DW-1:0]  r_den  [G+1];

    logic [DW-1:0]  n_rem  [G+1][NCH];
    logic [G-1:0]   n_lo   [G+1][NCH];
    logic [G-1:0]   n_q    [G+1][NCH];

    // code search, index 0 holds the table index
    logic [G-1:0] r_sidx [NSRC+1][NCH];
    logic [7:0]   r_sc   [NSRC+1][NCH];
    logic [7:0]   n_sc   [NSRC+1][NCH];

    assign busy = 1'b0;
    assign n_y  = (i_chroma_y == 16'd0) ? 16'd1 : i_chroma_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // divider setup and steps
    always_comb begin
        logic [PPW-1:0] p;
        logic [DW-1:0]  pl;
        logic [AW-1:0]  a;
        logic [DW:0]    sh;
        for (int c = 0; c < NCH; c++) begin
            p           = r_p[c];
            pl          = p[DW-1:0];
            a           = (AW'(pl) << G) - AW'(pl) + AW'(r_den4 >> 1);
            n_rem[0][c] = a[AW-1:G];
            n_lo[0][c]  = a[G-1:0];
            n_q[0][c]   = '0;
            for (int s = 1; s <= G; s++) begin
                sh = {r_rem[s-1][c], r_lo[s-1][c][G-1]};
                if (sh >= {1'b0, r_den[s-1]}) begin
                    n_rem[s][c] = DW'(sh - {1'b0, r_den[s-1]});
                    n_q[s][c]   = {r_q[s-1][c][G-2:0], 1'b1};
                end else begin
                    n_rem[s][c] = sh[DW-1:0];
                    n_q[s][c]   = {r_q[s-1][c][G-2:0], 1'b0};
                end
                n_lo[s][c] = r_lo[s-1][c] << 1;
            end
        end
    end

    // binary search for the number of code thresholds at or below the index
    always_comb begin
        logic [7:0] cand;
        for (int c = 0; c < NCH; c++) begin
            n_sc[0][c] = '0;
            for (int s = 1; s <= NSRC; s++) begin
                cand = r_sc[s-1][c] | (8'd1 << (NSRC - s));
                if (THR[cand][G-1:0] <= r_sidx[s-1][c]) begin
                    n_sc[s][c] = cand;
                end else begin
                    n_sc[s][c] = r_sc[s-1][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= i_chroma_x;
        r_y    <= n_y;
        r_z    <= 18'sd65535 - $signed({2'b00, i_chroma_x}) - $signed({2'b00, n_y});
        r_lvl1 <= i_level;

        r_y2   <= r_y;
        r_lvl2 <= r_lvl1;
        for (int c = 0; c < NCH; c++) begin
            r_px[c] <= PW'(COEF[3*c])     * PW'($signed({1'b0, r_x}));
            r_py[c] <= PW'(COEF[3*c + 1]) * PW'($signed({1'b0, r_y}));
            r_pz[c] <= PW'(COEF[3*c + 2]) * PW'(r_z);
        end

        r_lvl3 <= r_lvl2;
        r_den3 <= ((DW'(r_y2) << 8) - DW'(r_y2)) << CF;
        for (int c = 0; c < NCH; c++) begin
            r_num[c] <= NW'(r_px[c]) + NW'(r_py[c]) + NW'(r_pz[c]);
        end

        r_den4 <= r_den3;
        for (int c = 0; c < NCH; c++) begin
            r_p[c]     <= PPW'(r_num[c][NW-2:0]) * PPW'(r_lvl3);
            r_zero4[c] <= (r_num[c] <= 0) || (r_lvl3 == 8'd0);
        end

        r_den[0]  <= r_den4;
        r_zero[0] <= r_zero4;
        for (int c = 0; c < NCH; c++) begin
            r_sat[0][c] <= r_p[c] >= PPW'(r_den4);
        end
        for (int s = 1; s <= G; s++) begin
            r_den[s]  <= r_den[s-1];
            r_sat[s]  <= r_sat[s-1];
            r_zero[s] <= r_zero[s-1];
        end
        for (int s = 0; s <= G; s++) begin
            for (int c = 0; c < NCH; c++) begin
                r_rem[s][c] <= n_rem[s][c];
                r_lo[s][c]  <= n_lo[s][c];
                r_q[s][c]   <= n_q[s][c];
            end
        end

        for (int c = 0; c < NCH; c++) begin
            if (r_zero[G][c]) begin
                r_sidx[0][c] <= '0;
            end else if (r_sat[G][c]) begin
                r_sidx[0][c] <= N1;
            end else begin
                r_sidx[0][c] <= r_q[G][c];
            end
            for (int s = 0; s <= NSRC; s++) begin
                r_sc[s][c] <= n_sc[s][c];
            end
            for (int s = 1; s <= NSRC; s++) begin
                r_sidx[s][c] <= r_sidx[s-1][c];
            end
        end
    end

    assign o_done  = r_vld[LAT-1];
    assign o_red   = r_sc[NSRC][0];
    assign o_green = r_sc[NSRC][1];
    assign o_blue  = r_sc[NSRC][2];

endmodule
`default_nettype wire

>>> verif/tb_cie_xy_to_rgb_core.sv
// ----------------------------------------------------------------------------
// tb_cie_xy_to_rgb_core
// Self-checking bench for the xy-to-sRGB core. A predictor builds its own
// inverse-gamma table and fixed-point matrix and checks every strobed result
// in order. Stimulus is directed corner cases followed by random chromaticity
// and level values, sent with and without random idle bursts on the command side.
// ----------------------------------------------------------------------------
class rgb_scoreboard;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef longint unsigned t_u64;

    localparam int GBITS = 12;
    localparam int CFRAC = 16;
    localparam longint unsigned N1 = (64'd1 << GBITS) - 1;
    localparam longint unsigned Q30 = 64'd1 << 30;

    rgb_t       pending[$];
    logic [7:0] gamma_lut[1 << GBITS];
    longint     coef[9];
    int         errors;

    function new();
        int mat[9];
        longint mag;
        longint unsigned thr;
        int code;
        mat = '{32404542, -15371385, -4985314, -9692660, 18760108, 415560,
                556434, -2040259, 10572252};
        errors = 0;
        for (int i = 0; i < 9; i++) begin
            mag = (mat[i] < 0) ? -longint'(mat[i]) : longint'(mat[i]);
            mag = ((mag << CFRAC) + 5000000) / 10000000;
            coef[i] = (mat[i] < 0) ? -mag : mag;
        end
        code = 1;
        thr = code_start(1);
        for (int i = 0; i < (1 << GBITS); i++) begin
            while (code <= 255 && thr <= i) begin
                code++;
                if (code <= 255) thr = code_start(code);
            end
            gamma_lut[i] = 8'(code - 1);
        end
    endfunction

    function longint unsigned fifth_pow(longint unsigned r);
        longint unsigned r2;
        longint unsigned r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // first table index that encodes to code k
    function longint unsigned code_start(int k);
        longint unsigned w;
        longint unsigned w2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned lin;
        lo = 0;
        hi = Q30;
        if (k <= 10) begin
            lin = ((t_u64'(2 * k - 1) * 100) << 30) / 658920;
        end else begin
            w  = (t_u64'(400 * k + 5410) << 30) / 107610;
            w2 = (w * w) >> 30;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (fifth_pow(mid) <= w2) lo = mid;
                else hi = mid - 1;
            end
            lin = (w2 * lo) >> 30;
        end
        return (lin * N1 + Q30 - 1) >> 30;
    endfunction

    function logic [7:0] encode_channel(int row, longint x, longint y, longint z,
                                        longint lvl);
        longint num;
        longint unsigned den;
        longint unsigned p;
        longint unsigned idx;
        num = coef[row*3] * x + coef[row*3+1] * y + coef[row*3+2] * z;
        if (num <= 0 || lvl == 0) return gamma_lut[0];
        den = (t_u64'(255) * t_u64'(y)) << CFRAC;
        p   = t_u64'(lvl) * t_u64'(num);
        if (p >= den) idx = N1;
        else idx = (p * N1 + den / 2) / den;
        return gamma_lut[idx & N1];
    endfunction

    function void note_command(logic [15:0] cx, logic [15:0] cy, logic [7:0] lvl);
        longint x;
        longint y;
        longint z;
        rgb_t e;
        x = cx;
        y = (cy == 0) ? 1 : cy;
        z = 65535 - x - y;
        e.red   = encode_channel(0, x, y, z, lvl);
        e.green = encode_channel(1, x, y, z, lvl);
        e.blue  = encode_channel(2, x, y, z, lvl);
        pending.push_back(e);
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rgb_t e;
        if (pending.size() == 0) begin
            $error("result with no command outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (r !== e.red) begin
            $error("red expected %0d actual %0d", e.red, r);
            errors++;
        end
        if (g !== e.green) begin
            $error("green expected %0d actual %0d", e.green, g);
            errors++;
        end
        if (b !== e.blue) begin
            $error("blue expected %0d actual %0d", e.blue, b);
            errors++;
        end
    endfunction
endclass

module tb_cie_xy_to_rgb_core;
    import cxr_pkg::*;

    localparam int LATENCY     = DEF_GAMMA_TABLE_BITS + 14;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_chroma_x;
    logic [15:0] i_chroma_y;
    logic [7:0]  i_level;
    logic        o_done;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    rgb_scoreboard sb;
    int            cycles;

    cie_xy_to_rgb_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_chroma_x (i_chroma_x),
        .i_chroma_y (i_chroma_y),
        .i_level    (i_level),
        .o_done     (o_done),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // command transfer and result capture, both on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_command(i_chroma_x, i_chroma_y, i_level);
        end
        if (i_rst_n && o_done) begin
            sb.check_result(o_red, o_green, o_blue);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a rising edge, returns at the edge that takes the command
    task automatic send_color(logic [15:0] cx, logic [15:0] cy, logic [7:0] lvl);
        start      <= 1'b1;
        i_chroma_x <= cx;
        i_chroma_y <= cy;
        i_level    <= lvl;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random(bit gaps);
        logic [15:0] cx;
        logic [15:0] cy;
        if ($urandom_range(0, 3) != 0) begin
            // mostly physical chromaticities, x + y within one
            cx = 16'($urandom_range(0, 65535));
            cy = 16'($urandom_range(0, 65535 - cx));
        end else begin
            cx = 16'($urandom);
            cy = 16'($urandom);
        end
        send_color(cx, cy, 8'($urandom));
        if (gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 17));
    endtask

    initial begin
        sb         = new();
        cycles     = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_chroma_x = '0;
        i_chroma_y = '0;
        i_level    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: zero y, zero level, full level, x + y over one, white, primaries
        send_color(16'd0, 16'd0, 8'd0);
        send_color(16'd0, 16'd0, 8'd255);
        send_color(16'd65535, 16'd0, 8'd255);
        send_color(16'd65535, 16'd65535, 8'd255);
        send_color(16'd0, 16'd65535, 8'd255);
        send_color(16'd20493, 16'd21561, 8'd255);
        send_color(16'd20493, 16'd21561, 8'd1);
        send_color(16'd20493, 16'd21561, 8'd128);
        send_color(16'd20493, 16'd21561, 8'd0);
        send_color(16'd41942, 16'd21627, 8'd255);
        send_color(16'd19661, 16'd39321, 8'd255);
        send_color(16'd9830, 16'd3932, 8'd255);
        send_color(16'd40000, 16'd40000, 8'd200);
        send_color(16'd32768, 16'd32767, 8'd255);
        send_color(16'd1, 16'd1, 8'd255);
        send_color(16'd21845, 16'd21845, 8'd64);
        send_color(16'hAAAA, 16'h5555, 8'hAA);
        send_color(16'h5555, 16'hAAAA, 8'h55);
        idle_cycles($urandom_range(1, 17));

        for (int i = 0; i < 150; i++) send_random(1'b1);

        // hold off until the pipeline drains
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);

        for (int i = 0; i < 150; i++) send_random(1'b1);
        for (int i = 0; i < 100; i++) send_random(1'b0);
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/cxr_pkg.sv
rtl/cie_xy_to_rgb_core.sv
verif/tb_cie_xy_to_rgb_core.sv
